### sv/sha256_pkg.sv
// shared types and constants of the sha-256 byte-stream digest block
// round constants, initial hash values, controller states and the
// command and status groups between controller and datapath
package sha256_pkg;

    localparam int WORD_W = 32;
    localparam int ROUND_CNT = 64;
    localparam int ROUND_W = $clog2(ROUND_CNT);
    localparam int FILL_W = 6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] LEN_POS = FILL_W'(56);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(63);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_CNT - 1);
    // schedule step t+1 expands once t+1 reaches 16
    localparam logic [ROUND_W-1:0] EXPAND_FROM = ROUND_W'(15);

    localparam logic [WORD_W-1:0] ROUND_K [ROUND_CNT] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_PRIME,
        S_ROUND,
        S_FOLD,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        BSEL_IN,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic               load_byte;
        byte_sel_t          byte_sel;
        logic               prime;
        logic               round;
        logic               fold;
        logic               finish;
        logic [ROUND_W-1:0] round_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
        logic out_busy;
    } dp_status_t;

endpackage

### sv/sha256_ctrl.sv
// controller of the sha-256 digest block: byte intake, padding sequence,
// round counting and digest hand-off
// depends on sha256_pkg
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    input  logic       is_last,
    input  logic       message_empty,
    output logic       msg_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t        state_reg, state_next;
    ctrl_state_t        ret_reg, ret_next;
    logic [ROUND_W-1:0] round_reg, round_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    if (message_empty)
                        state_next = S_PAD_MARK;
                    else if (status.fill_last)
                    begin
                        state_next = S_PRIME;
                        ret_next   = is_last ? S_PAD_MARK : S_IDLE;
                    end
                    else
                        state_next = is_last ? S_PAD_MARK : S_IDLE;
                end
            end
            S_PAD_MARK:
            begin
                if (status.fill_last)
                begin
                    state_next = S_PRIME;
                    ret_next   = S_PAD_ZERO;
                end
                else
                    state_next = S_PAD_ZERO;
            end
            S_PAD_ZERO:
            begin
                if (status.fill_at_len)
                    state_next = S_PAD_LEN;
                else if (status.fill_last)
                begin
                    state_next = S_PRIME;
                    ret_next   = S_PAD_ZERO;
                end
            end
            S_PAD_LEN:
            begin
                if (status.fill_last)
                begin
                    state_next = S_PRIME;
                    ret_next   = S_DONE;
                end
            end
            S_PRIME:
            begin
                state_next = S_ROUND;
                round_next = '0;
            end
            S_ROUND:
            begin
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == LAST_ROUND)
                    state_next = S_FOLD;
            end
            S_FOLD:
                state_next = ret_reg;
            S_DONE:
            begin
                if (!status.out_busy)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        msg_ready     = 1'b0;
        cmd           = '0;
        cmd.byte_sel  = BSEL_IN;
        cmd.round_idx = round_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                msg_ready     = 1'b1;
                cmd.load_byte = msg_valid && !message_empty;
            end
            S_PAD_MARK:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_sel  = BSEL_PAD;
            end
            S_PAD_ZERO:
            begin
                cmd.load_byte = !status.fill_at_len;
                cmd.byte_sel  = BSEL_ZERO;
            end
            S_PAD_LEN:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_sel  = BSEL_LEN;
            end
            S_PRIME:
                cmd.prime = 1'b1;
            S_ROUND:
                cmd.round = 1'b1;
            S_FOLD:
                cmd.fold = 1'b1;
            S_DONE:
                cmd.finish = !status.out_busy;
            default:
                cmd.load_byte = 1'b0;
        endcase
    end

endmodule

### sv/sha256_dp.sv
// datapath of the sha-256 digest block: byte window and message schedule,
// round unit, chaining values, bit length and digest output register
// depends on sha256_pkg
module sha256_dp
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [63:0] digest_part,
    output logic [1:0]  part_index,
    output logic        last_part
);

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 16-word window, oldest word in the top bits
    logic [511:0]          win_reg, win_next;
    logic [31:0]           wt_reg, wt_next;
    logic [7:0][31:0]      v_reg, v_next;
    logic [7:0][31:0]      h_reg, h_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [63:0]           len_reg, len_next;
    logic [255:0]          dig_reg, dig_next;
    logic [1:0]            part_reg, part_next;
    logic                  dvalid_reg, dvalid_next;

    logic [7:0]  byte_mux;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2, ch, mj, s0_big, s1_big;
    logic [31:0] ra, rb, rc, re, rf, rg, rh;
    logic        out_fire;

    assign w0  = win_reg[511 -: 32];
    assign w1  = win_reg[479 -: 32];
    assign w9  = win_reg[223 -: 32];
    assign w14 = win_reg[63 -: 32];

    assign out_fire = dvalid_reg && digest_ready;

    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_IN:   byte_mux = data_byte;
            BSEL_PAD:  byte_mux = PAD_BYTE;
            BSEL_ZERO: byte_mux = 8'h00;
            BSEL_LEN:  byte_mux = len_reg[63:56];
            default:   byte_mux = 8'h00;
        endcase
    end

    // schedule runs one step ahead of the rounds
    always_comb
    begin
        if (cmd.round_idx >= EXPAND_FROM)
            w_new = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
                  + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;
        else
            w_new = w0;
    end

    assign ra = v_reg[0];
    assign rb = v_reg[1];
    assign rc = v_reg[2];
    assign re = v_reg[4];
    assign rf = v_reg[5];
    assign rg = v_reg[6];
    assign rh = v_reg[7];

    assign ch     = (re & rf) ^ (~re & rg);
    assign mj     = (ra & rb) ^ (ra & rc) ^ (rb & rc);
    assign s0_big = ror(ra, 2) ^ ror(ra, 13) ^ ror(ra, 22);
    assign s1_big = ror(re, 6) ^ ror(re, 11) ^ ror(re, 25);
    assign t1     = rh + s1_big + ch + ROUND_K[cmd.round_idx] + wt_reg;
    assign t2     = s0_big + mj;

    always_comb
    begin
        win_next    = win_reg;
        wt_next     = wt_reg;
        v_next      = v_reg;
        h_next      = h_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        dig_next    = dig_reg;
        part_next   = part_reg;
        dvalid_next = dvalid_reg;

        if (cmd.load_byte)
        begin
            win_next  = {win_reg[503:0], byte_mux};
            fill_next = fill_reg + FILL_W'(1);
            if (cmd.byte_sel == BSEL_IN)
                len_next = len_reg + 64'd8;
            else if (cmd.byte_sel == BSEL_LEN)
                len_next = {len_reg[55:0], 8'h00};
        end

        if (cmd.prime || cmd.round)
        begin
            wt_next  = w_new;
            win_next = {win_reg[479:0], w_new};
        end

        if (cmd.prime)
            v_next = h_reg;

        if (cmd.round)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end

        if (cmd.fold)
        begin
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + v_reg[i];
        end

        if (out_fire)
        begin
            dig_next  = {dig_reg[191:0], 64'd0};
            part_next = part_reg + 2'd1;
            if (part_reg == 2'd3)
                dvalid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            for (int i = 0; i < 8; i++)
            begin
                dig_next[255 - 32*i -: 32] = h_reg[i];
                h_next[i]                  = HASH_IV[i];
            end
            part_next   = 2'd0;
            dvalid_next = 1'b1;
            len_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= HASH_IV[i];
            fill_reg   <= '0;
            len_reg    <= '0;
            part_reg   <= '0;
            dvalid_reg <= 1'b0;
        end
        else
        begin
            h_reg      <= h_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            part_reg   <= part_next;
            dvalid_reg <= dvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        wt_reg  <= wt_next;
        v_reg   <= v_next;
        dig_reg <= dig_next;
    end

    assign status.fill_last   = (fill_reg == FILL_LAST);
    assign status.fill_at_len = (fill_reg == LEN_POS);
    assign status.out_busy    = dvalid_reg;

    assign digest_valid = dvalid_reg;
    assign digest_part  = dig_reg[255:192];
    assign part_index   = part_reg;
    assign last_part    = (part_reg == 2'd3);

endmodule

### sv/sha256_message_digest.sv
// top level of the sha-256 byte-stream digest block
// joins the controller and the datapath; depends on sha256_pkg,
// sha256_ctrl and sha256_dp
//
//   channel   direction  handshake                   payload
//   msg       in         msg_valid / msg_ready       data_byte, is_last, message_empty
//   digest    out        digest_valid / digest_ready digest_part, part_index, last_part
//
// message bytes are taken while the controller is idle; every 64th byte adds a compression
// (1 schedule prime, 64 rounds on one shared round unit, 1 chaining fold)
// ending a message feeds pad and length bytes with one or two
// compressions before the digest, which waits until the previous digest has left
// the digest leaves as 4 transfers, part 0 first, while the next message comes in
// reset is asynchronous, active low; no clearing pass is needed
module sha256_message_digest
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        message_empty,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [63:0] digest_part,
    output logic [1:0]  part_index,
    output logic        last_part
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing of intake, padding and rounds
    sha256_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg_valid     (msg_valid),
        .is_last       (is_last),
        .message_empty (message_empty),
        .msg_ready     (msg_ready),
        .status        (status),
        .cmd           (cmd)
    );

    // window, round unit, chaining values and digest register
    sha256_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .status       (status),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_part  (digest_part),
        .part_index   (part_index),
        .last_part    (last_part)
    );

    // an ending transfer starts the padding, or first a compression of the full block, so intake closes at once
    a_end_closes_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_ready && (message_empty || is_last)) |=> !msg_ready)
        else $error("intake still open after message end");

    // a digest starts at part 0
    a_digest_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (part_index == 2'd0))
        else $error("digest did not start at part 0");

    // parts of one digest follow without a gap in their count
    a_parts_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && !last_part)
            |=> (digest_valid && (part_index == $past(part_index) + 2'd1)))
        else $error("digest part out of order");

    // intake never takes a byte during compression (schedule prime, rounds, chaining fold)
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.round || cmd.prime || cmd.fold) |-> !msg_ready)
        else $error("intake open while compressing");

endmodule
